[rtl/core/pffa_pkg.sv]
// Package for the page-fault frame allocator.
// Holds the field widths, result status codes, register addresses and defaults.
// No dependencies; used by page_fault_frame_allocator.
package pffa_pkg;

   // Default sizes of the page table and of the frame table.
   localparam int DEFAULT_MAX_PAGES  = 64;
   localparam int DEFAULT_MAX_FRAMES = 16;

   // Fixed field widths of the request and result items.
   localparam int PAGE_W     = 6;
   localparam int RND_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int FRAME_W    = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Configuration registers.
   localparam int PAGES_CSR_W  = 7;
   localparam int FRAMES_CSR_W = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [PAGES_CSR_W-1:0]  PAGES_RESET  = PAGES_CSR_W'(64);
   localparam logic [FRAMES_CSR_W-1:0] FRAMES_RESET = FRAMES_CSR_W'(16);

   // Register index as seen in address bit 2.
   localparam logic CSR_IDX_PAGES  = 1'b0;
   localparam logic CSR_IDX_FRAMES = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_FREE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_VICTIM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESIDENT = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

endpackage

[rtl/core/page_fault_frame_allocator.sv]
// Page-fault frame allocator: page table, frame table and a small sequencer.
// The victim modulo runs on a compare/subtract unit; the free-frame search scans busy bits.
// Depends on pffa_pkg.
//
// An accepted item is checked; an out-of-range page then finishes, a resident page reads
// its frame, a fault takes the first free frame, and when none is free a victim is chosen
// (a one-frame-per-cycle scan, then a bit-serial modulo of the random word) and replaced.
// One item is worked on at a time; the next is accepted once the sequencer is
// back in idle, even while the last result still waits. Synchronous active-high
// reset clears all valid and busy bits, restores 64 pages and 16 frames.
module page_fault_frame_allocator #(
   parameter int MAX_PAGES  = pffa_pkg::DEFAULT_MAX_PAGES,
   parameter int MAX_FRAMES = pffa_pkg::DEFAULT_MAX_FRAMES
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel. tdata: page [5:0], random_word [21:6], zero [23:22].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pffa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result channel. tdata: status [1:0], frame [5:2], evicted [6],
   // evicted_page [12:7], zero [15:13].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pffa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pffa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pffa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int PAGE_IW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int FRAME_IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PCNT_W   = $clog2(MAX_PAGES + 1);
   localparam int FCNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int REM_W    = FCNT_W + 1;
   localparam int DCNT_W   = $clog2(pffa_pkg::RND_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RESIDENT,
      ST_SCAN,
      ST_DIVIDE,
      ST_OWNER,
      ST_EVICT,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type                          state_ff;
   logic [pffa_pkg::PAGES_CSR_W-1:0]   pages_csr_ff;
   logic [pffa_pkg::FRAMES_CSR_W-1:0]  frames_csr_ff;

   logic [PCNT_W-1:0]                  npages_ff;
   logic [FCNT_W-1:0]                  nframes_ff;
   logic [pffa_pkg::PAGE_W-1:0]        page_ff;
   logic [pffa_pkg::RND_W-1:0]         rnd_ff;
   logic [FRAME_IW-1:0]                scan_ff;
   logic [REM_W-1:0]                   rem_ff;
   logic [DCNT_W-1:0]                  div_cnt_ff;
   logic [FRAME_IW-1:0]                frame_ff;

   logic [pffa_pkg::STATUS_W-1:0]      res_status_ff;
   logic                               res_evicted_ff;
   logic [pffa_pkg::PAGE_W-1:0]        res_evpage_ff;

   logic                               rsp_valid_ff;
   logic [pffa_pkg::STATUS_W-1:0]      rsp_status_ff;
   logic [pffa_pkg::FRAME_W-1:0]       rsp_frame_ff;
   logic                               rsp_evicted_ff;
   logic [pffa_pkg::PAGE_W-1:0]        rsp_evpage_ff;

   logic [MAX_PAGES-1:0]               page_valid_ff;
   logic [MAX_FRAMES-1:0]              frame_busy_ff;

   // Page-to-frame and frame-to-owner stores; entries are written before use.
   logic [FRAME_IW-1:0]                page_frame_mem [MAX_PAGES];
   logic [pffa_pkg::PAGE_W-1:0]        frame_owner_mem [MAX_FRAMES];
   logic [FRAME_IW-1:0]                page_frame_rd_ff;
   logic [pffa_pkg::PAGE_W-1:0]        owner_rd_ff;

   logic [PCNT_W-1:0]                  npages_in;
   logic [FCNT_W-1:0]                  nframes_in;
   logic [PAGE_IW-1:0]                 page_idx;
   logic [PAGE_IW-1:0]                 owner_idx;
   logic                               page_in_range;
   logic                               owner_in_range;
   logic                               scan_last;
   logic [REM_W-1:0]                   rem_shift;
   logic                               rem_ge;
   logic [REM_W-1:0]                   rem_in;
   logic                               req_accept;
   logic                               csr_write;

   // Register counts are clamped to 1..MAX at the start of each item.
   always_comb begin
      if (pages_csr_ff == '0) begin
         npages_in = PCNT_W'(1);
      end else if (32'(pages_csr_ff) > 32'(MAX_PAGES)) begin
         npages_in = PCNT_W'(MAX_PAGES);
      end else begin
         npages_in = PCNT_W'(pages_csr_ff);
      end
      if (frames_csr_ff == '0) begin
         nframes_in = FCNT_W'(1);
      end else if (32'(frames_csr_ff) > 32'(MAX_FRAMES)) begin
         nframes_in = FCNT_W'(MAX_FRAMES);
      end else begin
         nframes_in = FCNT_W'(frames_csr_ff);
      end
   end

   assign page_idx       = PAGE_IW'(page_ff);
   assign owner_idx      = PAGE_IW'(owner_rd_ff);
   assign page_in_range  = 32'(page_ff) < 32'(npages_ff);
   assign owner_in_range = 32'(owner_rd_ff) < 32'(MAX_PAGES);
   assign scan_last      = (32'(scan_ff) + 32'd1) == 32'(nframes_ff);

   // Compare/subtract step of the restoring modulo, one bit per cycle.
   assign rem_shift = {rem_ff[REM_W-2:0], rnd_ff[pffa_pkg::RND_W-1]};
   assign rem_ge    = rem_shift >= REM_W'(nframes_ff);
   assign rem_in    = rem_ge ? (rem_shift - REM_W'(nframes_ff)) : rem_shift;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pages_csr_ff   <= pffa_pkg::PAGES_RESET;
         frames_csr_ff  <= pffa_pkg::FRAMES_RESET;
         page_valid_ff  <= '0;
         frame_busy_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_paddr[2])
               pffa_pkg::CSR_IDX_PAGES: begin
                  pages_csr_ff <= csr_pwdata[pffa_pkg::PAGES_CSR_W-1:0];
               end
               pffa_pkg::CSR_IDX_FRAMES: begin
                  frames_csr_ff <= csr_pwdata[pffa_pkg::FRAMES_CSR_W-1:0];
               end
               default: begin
               end
            endcase
         end

         // In ST_FINISH a drained result is replaced by the new one below.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  page_ff    <= req_tdata[pffa_pkg::PAGE_W-1:0];
                  rnd_ff     <= req_tdata[pffa_pkg::PAGE_W +: pffa_pkg::RND_W];
                  npages_ff  <= npages_in;
                  nframes_ff <= nframes_in;
                  state_ff   <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               res_evicted_ff <= 1'b0;
               res_evpage_ff  <= '0;
               frame_ff       <= '0;
               scan_ff        <= '0;
               if (!page_in_range) begin
                  res_status_ff <= pffa_pkg::STATUS_RANGE;
                  state_ff      <= ST_FINISH;
               end else if (page_valid_ff[page_idx]) begin
                  state_ff <= ST_RESIDENT;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_RESIDENT: begin
               res_status_ff <= pffa_pkg::STATUS_RESIDENT;
               frame_ff      <= page_frame_rd_ff;
               state_ff      <= ST_FINISH;
            end
            ST_SCAN: begin
               if (!frame_busy_ff[scan_ff]) begin
                  res_status_ff <= pffa_pkg::STATUS_FREE;
                  frame_ff      <= scan_ff;
                  state_ff      <= ST_UPDATE;
               end else if (scan_last) begin
                  rem_ff     <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIVIDE;
               end else begin
                  scan_ff <= scan_ff + FRAME_IW'(1);
               end
            end
            ST_DIVIDE: begin
               rem_ff     <= rem_in;
               rnd_ff     <= {rnd_ff[pffa_pkg::RND_W-2:0], 1'b0};
               div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               if (div_cnt_ff == DCNT_W'(pffa_pkg::RND_W - 1)) begin
                  state_ff <= ST_OWNER;
               end
            end
            ST_OWNER: begin
               frame_ff <= FRAME_IW'(rem_ff);
               state_ff <= ST_EVICT;
            end
            ST_EVICT: begin
               if (owner_in_range) begin
                  page_valid_ff[owner_idx] <= 1'b0;
               end
               res_status_ff  <= pffa_pkg::STATUS_VICTIM;
               res_evicted_ff <= 1'b1;
               res_evpage_ff  <= owner_rd_ff;
               state_ff       <= ST_UPDATE;
            end
            ST_UPDATE: begin
               frame_busy_ff[frame_ff] <= 1'b1;
               page_valid_ff[page_idx] <= 1'b1;
               state_ff                <= ST_FINISH;
            end
            ST_FINISH: begin
               // Hold the finished item until the output register is free.
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_frame_ff   <= pffa_pkg::FRAME_W'(frame_ff);
                  rsp_evicted_ff <= res_evicted_ff;
                  rsp_evpage_ff  <= res_evpage_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         page_frame_rd_ff <= page_frame_mem[page_idx];
      end
      if (state_ff == ST_UPDATE) begin
         page_frame_mem[page_idx] <= frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OWNER) begin
         owner_rd_ff <= frame_owner_mem[FRAME_IW'(rem_ff)];
      end
      if (state_ff == ST_UPDATE) begin
         frame_owner_mem[frame_ff] <= page_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_evpage_ff, rsp_evicted_ff, rsp_frame_ff, rsp_status_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == pffa_pkg::CSR_IDX_FRAMES) ?
                       pffa_pkg::CSR_DATA_W'(frames_csr_ff) :
                       pffa_pkg::CSR_DATA_W'(pages_csr_ff);

   // The victim frame always lies below the clamped frame count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OWNER) |-> (rem_ff < REM_W'(nframes_ff)))
      else $error("victim remainder not below frame count");

   // The scan never looks past the allocatable frames.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(scan_ff) < 32'(nframes_ff)))
      else $error("free-frame scan out of range");

   // A mapped frame is marked busy and its page valid after the update.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=>
         (frame_busy_ff[$past(frame_ff)] && page_valid_ff[$past(page_idx)]))
      else $error("allocation not recorded");

   // Only a victim replacement reports an eviction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_evicted_ff == (rsp_status_ff == pffa_pkg::STATUS_VICTIM)))
      else $error("eviction flag disagrees with status");

   // A finished item is only loaded into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FINISH))
      else $error("result overwritten while pending");

endmodule

[sim/pffa_checker.sv]
`timescale 1ns / 100ps
// Checker for the page-fault frame allocator: watches the request, result and register ports,
// keeps its own page and frame tables, and compares every result with its prediction.
// Depends on pffa_pkg.
module pffa_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // tdata: page [5:0], random_word [21:6], zero [23:22].
   input  logic [pffa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: status [1:0], frame [5:2], evicted [6], evicted_page [12:7], zero [15:13].
   input  logic [pffa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pffa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending,
   output int                                free_count,
   output int                                victim_count,
   output int                                resident_count,
   output int                                range_count
);
   import pffa_pkg::*;

   localparam int NUM_PAGES  = DEFAULT_MAX_PAGES;
   localparam int NUM_FRAMES = DEFAULT_MAX_FRAMES;

   typedef struct packed {
      logic [2:0]          pad;
      logic [PAGE_W-1:0]   evicted_page;
      logic                evicted;
      logic [FRAME_W-1:0]  frame;
      logic [STATUS_W-1:0] status;
   } fault_rsp_type;

   logic [PAGES_CSR_W-1:0]  pages_reg;
   logic [FRAMES_CSR_W-1:0] frames_reg;
   logic                    page_mapped  [NUM_PAGES];
   logic [FRAME_W-1:0]      mapped_frame [NUM_PAGES];
   logic                    frame_taken  [NUM_FRAMES];
   logic [PAGE_W-1:0]       frame_holder [NUM_FRAMES];
   fault_rsp_type           expected_rsps [$];
   int                      errors;
   int                      tally [4];

   function automatic int clamp_count(int v, int top_val);
      if (v == 0) return 1;
      if (v > top_val) return top_val;
      return v;
   endfunction

   // Updates the tables for one fault and returns the result it must produce.
   function automatic fault_rsp_type allocate_frame(logic [PAGE_W-1:0] pg,
                                                    logic [RND_W-1:0] rw);
      int            npages;
      int            nframes;
      bit            found;
      fault_rsp_type r;
      npages  = clamp_count(int'(pages_reg), NUM_PAGES);
      nframes = clamp_count(int'(frames_reg), NUM_FRAMES);
      r = '0;
      found = 1'b0;
      if (int'(pg) >= npages) begin
         r.status = STATUS_RANGE;
      end else if (page_mapped[pg]) begin
         r.status = STATUS_RESIDENT;
         r.frame  = mapped_frame[pg];
      end else begin
         for (int j = 0; j < nframes && !found; j++) begin
            if (!frame_taken[j]) begin
               r.frame = FRAME_W'(j);
               found = 1'b1;
            end
         end
         if (found) begin
            r.status = STATUS_FREE;
         end else begin
            r.status       = STATUS_VICTIM;
            r.frame        = FRAME_W'(int'(rw) % nframes);
            r.evicted      = 1'b1;
            r.evicted_page = frame_holder[r.frame];
            page_mapped[r.evicted_page] = 1'b0;
         end
         frame_taken[r.frame]  = 1'b1;
         frame_holder[r.frame] = pg;
         page_mapped[pg]       = 1'b1;
         mapped_frame[pg]      = r.frame;
      end
      return r;
   endfunction

   task automatic check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      fault_rsp_type want;
      fault_rsp_type got;
      if (reset) begin
         pages_reg  = PAGES_RESET;
         frames_reg = FRAMES_RESET;
         foreach (page_mapped[i]) page_mapped[i] = 1'b0;
         foreach (frame_taken[i]) frame_taken[i] = 1'b0;
         expected_rsps.delete();
         errors = 0;
         foreach (tally[i]) tally[i] = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_IDX_FRAMES) frames_reg = csr_pwdata[FRAMES_CSR_W-1:0];
               else pages_reg = csr_pwdata[PAGES_CSR_W-1:0];
            end else if (csr_paddr[2] == CSR_IDX_FRAMES) begin
               check_field("frames_in_use readback", int'(frames_reg), int'(csr_prdata));
            end else begin
               check_field("pages_in_use readback", int'(pages_reg), int'(csr_prdata));
            end
         end
         if (req_tvalid && req_tready) begin
            want = allocate_frame(req_tdata[PAGE_W-1:0], req_tdata[PAGE_W +: RND_W]);
            tally[want.status]++;
            expected_rsps.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = fault_rsp_type'(rsp_tdata);
            if (expected_rsps.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual 0x%04h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", int'(want.status), int'(got.status));
               check_field("frame", int'(want.frame), int'(got.frame));
               check_field("evicted", int'(want.evicted), int'(got.evicted));
               check_field("evicted_page", int'(want.evicted_page), int'(got.evicted_page));
            end
         end
      end
      // Outputs change only after the edge so the stimulus side never races them.
      fail_count     <= errors;
      pending        <= expected_rsps.size();
      free_count     <= tally[STATUS_FREE];
      victim_count   <= tally[STATUS_VICTIM];
      resident_count <= tally[STATUS_RESIDENT];
      range_count    <= tally[STATUS_RANGE];
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Top of the page-fault frame allocator testbench: clock, reset, fault and register stimulus
// with random gaps and stalls, and the final verdict. Depends on pffa_pkg,
// page_fault_frame_allocator and pffa_checker.
module tb_top;
   import pffa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 48;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int fail_count;
   int pending;
   int free_count;
   int victim_count;
   int resident_count;
   int range_count;
   int cycle_count = 0;
   int rx_hold;
   int fault_items = 0;
   int settings = 0;
   bit tx_quiet = 1'b0;
   bit rx_quiet = 1'b0;

   page_fault_frame_allocator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pffa_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending),
      .free_count(free_count), .victim_count(victim_count),
      .resident_count(resident_count), .range_count(range_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: after each accepted item, hold tready low for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rx_hold = rx_quiet ? 0 : $urandom_range(0, 15);
         if (rx_hold != 0) rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (rx_hold <= 1) rsp_tready <= 1'b1;
         rx_hold--;
      end
   end

   // Valid stays high between back-to-back items; it drops only before a gap or a drain.
   task automatic send_fault(input logic [PAGE_W-1:0] pg, input logic [RND_W-1:0] rw);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, rw, pg};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fault_items++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One write followed by a read of the same register.
   task automatic write_reg(input logic idx, input int value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_limits(input int npages, input int nframes);
      drain();
      write_reg(CSR_IDX_PAGES, npages);
      write_reg(CSR_IDX_FRAMES, nframes);
      settings++;
   endtask

   initial begin
      int phase_pages [6];
      int phase_frames [6];
      int span;
      logic [PAGE_W-1:0] pg;
      phase_pages  = '{64, 8, 20, 0, 64, 3};
      phase_frames = '{4, 16, 1, 0, 16, 2};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes: first free frames, then a hit on a resident page.
      send_fault(0, 16'h0000);
      send_fault(63, 16'hFFFF);
      send_fault(0, 16'h5A5A);
      // Zero registers count as one page and one frame.
      set_limits(0, 0);
      send_fault(1, 16'h1111);
      send_fault(0, 16'h2222);
      send_fault(63, 16'hFFFF);
      // A single frame forces a victim on every new page.
      set_limits(2, 1);
      send_fault(1, 16'hFFFF);
      send_fault(0, 16'h0000);
      // Values above the maximum count as the maximum; fill every frame, then evict.
      set_limits(127, 31);
      send_fault(63, 16'h8000);
      for (int p = 10; p < 24; p++) send_fault(PAGE_W'(p), RND_W'($urandom));
      send_fault(40, 16'hABCD);
      // Shrunk frame count: a page mapped above the limit is still reported resident.
      set_limits(127, 2);
      send_fault(40, 16'h1234);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 3) begin
            phase_pages[ph]  = $urandom_range(0, 127);
            phase_frames[ph] = $urandom_range(0, 31);
         end
         set_limits(phase_pages[ph], phase_frames[ph]);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         span = (phase_pages[ph] == 0) ? 1 : (phase_pages[ph] > 64 ? 64 : phase_pages[ph]);
         for (int i = 0; i < 100; i++) begin
            // Halfway through each phase the sender waits for every result to come back.
            if (i == 50) drain();
            if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom_range(0, 63));
            else pg = PAGE_W'($urandom_range(0, span - 1));
            send_fault(pg, RND_W'($urandom));
         end
      end
      drain();

      $display("Sent %0d fault items over %0d register settings.", fault_items, settings);
      $display("Results: %0d free frame, %0d victim, %0d resident, %0d out of range.",
               free_count, victim_count, resident_count, range_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
